@@ rtl/lsq_pkg.sv @@
// ============================================================================
// lsq_pkg - shared types and codes for the linked stack/queue pool
// Operation and status codes, fixed field widths and the command/status
// structs that join the controller to the datapath.
// ============================================================================
package lsq_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int SLOT_BITS   = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_ENQ  = 2'd2,
        OP_DEQ  = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic update;
        logic tail;
        logic item_ld;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic refuse;
        logic need_tail;
        logic need_item;
    } t_dp_sts;

endpackage

@@ rtl/lsq_if.sv @@
// ============================================================================
// lsq_if - word channels of the linked stack/queue pool
// Operation channel into the block and result channel out of it, each with
// valid/ready handshake and its payload.
// ============================================================================
interface lsq_in_if #(
    parameter int ITEM_BITS = 32
);
    import lsq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   opcode;
    logic [ITEM_BITS-1:0] item_data;

    modport source (output valid, opcode, item_data, input ready);
    modport sink   (input valid, opcode, item_data, output ready);
endinterface

interface lsq_out_if #(
    parameter int ITEM_BITS = 32
);
    import lsq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot_index;
    logic [ITEM_BITS-1:0]   removed_item;
    logic [ITEM_BITS-1:0]   top_item;
    logic [ITEM_BITS-1:0]   front_item;
    logic                   stack_empty;
    logic                   queue_empty;
    logic                   pool_full;

    modport source (
        output valid, status, slot_index, removed_item, top_item, front_item,
               stack_empty, queue_empty, pool_full,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, removed_item, top_item, front_item,
               stack_empty, queue_empty, pool_full,
        output ready
    );
endinterface

@@ rtl/lsq_dp.sv @@
// ============================================================================
// lsq_dp - datapath of the linked stack/queue pool
// Slot link and item memories, head/tail/free pointers, cached top and front
// words, the working registers of one operation and the result register.
// ============================================================================
module lsq_dp #(
    parameter int POOL_DEPTH = 16,
    parameter int ITEM_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lsq_pkg::t_dp_cmd                i_cmd,
    output lsq_pkg::t_dp_sts                o_sts,
    input  logic [lsq_pkg::OP_BITS-1:0]     i_opcode,
    input  logic [ITEM_BITS-1:0]            i_item_data,
    output logic [lsq_pkg::STATUS_BITS-1:0] o_status,
    output logic [lsq_pkg::SLOT_BITS-1:0]   o_slot_index,
    output logic [ITEM_BITS-1:0]            o_removed_item,
    output logic [ITEM_BITS-1:0]            o_top_item,
    output logic [ITEM_BITS-1:0]            o_front_item,
    output logic                            o_stack_empty,
    output logic                            o_queue_empty,
    output logic                            o_pool_full
);
    import lsq_pkg::*;

    localparam int IDX_BITS = $clog2(POOL_DEPTH);
    localparam int PTR_BITS = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(POOL_DEPTH);

    // link of slot i reads as i-1 while i lies below r_low (never allocated)
    logic [PTR_BITS-1:0]    r_link_mem [POOL_DEPTH];
    logic [ITEM_BITS-1:0]   r_item_mem [POOL_DEPTH];

    logic [PTR_BITS-1:0]    r_free, r_sh, r_qh, r_qt, r_low;
    logic [ITEM_BITS-1:0]   r_top, r_front;

    t_op                    r_op;
    logic [ITEM_BITS-1:0]   r_data;
    t_status                r_status;
    logic [PTR_BITS-1:0]    r_slot;
    logic [ITEM_BITS-1:0]   r_removed;

    logic [PTR_BITS-1:0]    r_link_q;
    logic                   r_fresh;
    logic [PTR_BITS-1:0]    r_fresh_val;
    logic [ITEM_BITS-1:0]   r_item_q;

    logic [STATUS_BITS-1:0] r_o_status;
    logic [SLOT_BITS-1:0]   r_o_slot;
    logic [ITEM_BITS-1:0]   r_o_removed, r_o_top, r_o_front;
    logic                   r_o_sempty, r_o_qempty, r_o_full;

    t_op                    w_op;
    t_status                w_refuse_st;
    logic [PTR_BITS-1:0]    w_link_addr;
    logic                   w_fresh;
    logic [PTR_BITS-1:0]    w_fresh_val;
    logic [PTR_BITS-1:0]    w_next;
    logic                   w_need_item;
    logic                   w_lwr_en;
    logic [PTR_BITS-1:0]    w_lwr_addr;
    logic [PTR_BITS-1:0]    w_lwr_data;
    logic                   w_iwr_en;

    always_comb begin
        w_op = t_op'(i_opcode);
        unique case (w_op)
            OP_PUSH, OP_ENQ: begin
                w_link_addr = r_free;
                w_refuse_st = (r_free == NIL) ? ST_FULL : ST_DONE;
            end
            OP_POP: begin
                w_link_addr = r_sh;
                w_refuse_st = (r_sh == NIL) ? ST_EMPTY : ST_DONE;
            end
            default: begin
                w_link_addr = r_qh;
                w_refuse_st = (r_qh == NIL) ? ST_EMPTY : ST_DONE;
            end
        endcase
        w_fresh     = (w_link_addr < r_low);
        w_fresh_val = (w_link_addr == '0) ? NIL : w_link_addr - PTR_BITS'(1);
        w_next      = r_fresh ? r_fresh_val : r_link_q;
        w_need_item = ((r_op == OP_POP) || (r_op == OP_DEQ)) && (w_next != NIL);
    end

    assign o_sts.refuse    = (w_refuse_st != ST_DONE);
    assign o_sts.need_tail = (r_op == OP_ENQ) && (r_qh != NIL);
    assign o_sts.need_item = w_need_item;

    always_comb begin
        w_lwr_en   = 1'b0;
        w_lwr_addr = r_free;
        w_lwr_data = NIL;
        w_iwr_en   = 1'b0;
        if (i_cmd.update) begin
            w_lwr_en = 1'b1;
            unique case (r_op)
                OP_PUSH: begin
                    w_lwr_data = r_sh;
                    w_iwr_en   = 1'b1;
                end
                OP_ENQ: begin
                    w_iwr_en = 1'b1;
                    if (r_qh != NIL) begin
                        w_lwr_addr = r_qt;
                        w_lwr_data = r_free;
                    end
                end
                OP_POP: begin
                    w_lwr_addr = r_sh;
                    w_lwr_data = r_free;
                end
                default: begin
                    w_lwr_addr = r_qh;
                    w_lwr_data = r_free;
                end
            endcase
        end else if (i_cmd.tail) begin
            w_lwr_en   = 1'b1;
            w_lwr_addr = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lwr_en) begin
            r_link_mem[w_lwr_addr[IDX_BITS-1:0]] <= w_lwr_data;
        end
        if (i_cmd.load && !o_sts.refuse) begin
            r_link_q    <= r_link_mem[w_link_addr[IDX_BITS-1:0]];
            r_fresh     <= w_fresh;
            r_fresh_val <= w_fresh_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_iwr_en) begin
            r_item_mem[r_free[IDX_BITS-1:0]] <= r_data;
        end
        if (i_cmd.update && w_need_item) begin
            r_item_q <= r_item_mem[w_next[IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= PTR_BITS'(POOL_DEPTH - 1);
            r_sh    <= NIL;
            r_qh    <= NIL;
            r_qt    <= NIL;
            r_low   <= NIL;
            r_top   <= '0;
            r_front <= '0;
        end else if (i_cmd.update) begin
            unique case (r_op)
                OP_PUSH: begin
                    r_free <= w_next;
                    r_sh   <= r_free;
                    r_top  <= r_data;
                    if (r_free < r_low) begin
                        r_low <= r_free;
                    end
                end
                OP_ENQ: begin
                    r_free <= w_next;
                    r_qt   <= r_free;
                    if (r_qh == NIL) begin
                        r_qh    <= r_free;
                        r_front <= r_data;
                    end
                    if (r_free < r_low) begin
                        r_low <= r_free;
                    end
                end
                OP_POP: begin
                    r_free <= r_sh;
                    r_sh   <= w_next;
                    if (w_next == NIL) begin
                        r_top <= '0;
                    end
                end
                default: begin
                    r_free <= r_qh;
                    r_qh   <= w_next;
                    if (w_next == NIL) begin
                        r_qt    <= NIL;
                        r_front <= '0;
                    end
                end
            endcase
        end else if (i_cmd.item_ld) begin
            if (r_op == OP_POP) begin
                r_top <= r_item_q;
            end else begin
                r_front <= r_item_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= w_op;
            r_data    <= i_item_data;
            r_status  <= w_refuse_st;
            r_slot    <= '0;
            r_removed <= '0;
        end else if (i_cmd.update) begin
            unique case (r_op)
                OP_PUSH, OP_ENQ: r_slot <= r_free;
                OP_POP: begin
                    r_slot    <= r_sh;
                    r_removed <= r_top;
                end
                default: begin
                    r_slot    <= r_qh;
                    r_removed <= r_front;
                end
            endcase
        end
        if (i_cmd.out_ld) begin
            r_o_status  <= r_status;
            r_o_slot    <= SLOT_BITS'(r_slot);
            r_o_removed <= r_removed;
            r_o_top     <= r_top;
            r_o_front   <= r_front;
            r_o_sempty  <= (r_sh == NIL);
            r_o_qempty  <= (r_qh == NIL);
            r_o_full    <= (r_free == NIL);
        end
    end

    assign o_status       = r_o_status;
    assign o_slot_index   = r_o_slot;
    assign o_removed_item = r_o_removed;
    assign o_top_item     = r_o_top;
    assign o_front_item   = r_o_front;
    assign o_stack_empty  = r_o_sempty;
    assign o_queue_empty  = r_o_qempty;
    assign o_pool_full    = r_o_full;

    a_queue_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qh == NIL) == (r_qt == NIL))
        else $error("queue head and tail disagree on emptiness");

    a_full_has_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL) |-> !((r_sh == NIL) && (r_qh == NIL)))
        else $error("free list exhausted with both structures empty");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && (r_op == OP_PUSH)) |=> (r_sh != NIL) && (r_top == $past(r_data)))
        else $error("push did not set the stack top");

endmodule

@@ rtl/lsq_ctrl.sv @@
// ============================================================================
// lsq_ctrl - sequencer of the linked stack/queue pool
// Takes one operation word at a time, steps the datapath through link read,
// update, tail link or item refetch, then loads the result register.
// ============================================================================
module lsq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  lsq_pkg::t_dp_sts i_sts,
    output lsq_pkg::t_dp_cmd o_cmd
);
    import lsq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_TAIL   = 5'b00100,
        S_ITEM   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.refuse ? S_DONE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_sts.need_tail) begin
                    n_state = S_TAIL;
                end else if (i_sts.need_item) begin
                    n_state = S_ITEM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_DONE;
            end
            S_ITEM: begin
                o_cmd.item_ld = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the done step");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwritten while the receiver stalls");

    a_tail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && i_sts.need_tail) |=> (r_state == S_TAIL))
        else $error("enqueue behind a tail skipped the tail link");

endmodule

@@ rtl/linked_stack_queue_pool.sv @@
// ============================================================================
// linked_stack_queue_pool - stack and FIFO queue sharing a linked slot pool
// One stack and one queue draw slots from a common free list of POOL_DEPTH
// slots; each operation word gives exactly one result word.
// ============================================================================
// Usage:
//   i_in carries one operation word (push, pop, enqueue, dequeue plus an item
//   word); o_out returns one result word per operation: status, slot touched,
//   removed item, new top and front items and the empty/full flags.
//   One operation is in flight at a time. A refused operation goes from
//   the idle step straight to the done step; push, enqueue onto an empty
//   queue and pop or dequeue that empty their structure pass through the
//   update step; enqueue behind an existing tail and pop or dequeue that
//   leave items behind add a tail link or item step (extra write of the tail
//   link, or a refetch of the new top/front word from the item memory, which
//   has one registered read port). The result register loads as the done
//   step hands back to idle, where the next operation can be taken.
//   Reset (synchronous, active low) empties both structures and chains all
//   slots on the free list, highest index first; no clearing pass is needed.
//   A stalled receiver holds the result word; the block may take and work on
//   one more operation and then waits until the result register frees.
// ============================================================================
module linked_stack_queue_pool #(
    parameter int POOL_DEPTH = 16,
    parameter int ITEM_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lsq_in_if.sink           i_in,
    lsq_out_if.source        o_out
);
    import lsq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lsq_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .ITEM_BITS  (ITEM_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_in.opcode),
        .i_item_data    (i_in.item_data),
        .o_status       (o_out.status),
        .o_slot_index   (o_out.slot_index),
        .o_removed_item (o_out.removed_item),
        .o_top_item     (o_out.top_item),
        .o_front_item   (o_out.front_item),
        .o_stack_empty  (o_out.stack_empty),
        .o_queue_empty  (o_out.queue_empty),
        .o_pool_full    (o_out.pool_full)
    );

endmodule

@@ bench/lsq_pool_checker.sv @@
// ============================================================================
// lsq_pool_checker - result checker for the linked stack/queue pool
// Watches the operation and result channels and keeps its own copy of the
// slot pool, the free list and the stack and queue pointers. Every accepted
// operation word is run through this copy to give the result word it must
// cause. Every accepted result word is compared field by field with the
// oldest expected word.
// ============================================================================
module lsq_pool_checker #(
    parameter int POOL_DEPTH = 16,
    parameter int ITEM_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lsq_in_if    i_op_mon,
    lsq_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_refusals
);
    import lsq_pkg::*;

    localparam int PTR_BITS = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(POOL_DEPTH);

    typedef struct {
        t_status              status;
        logic [SLOT_BITS-1:0] slot;
        logic [ITEM_BITS-1:0] removed;
        logic [ITEM_BITS-1:0] top;
        logic [ITEM_BITS-1:0] front;
        logic                 stack_empty;
        logic                 queue_empty;
        logic                 pool_full;
    } t_pool_result;

    logic [ITEM_BITS-1:0] slot_word [POOL_DEPTH];
    logic [PTR_BITS-1:0]  slot_link [POOL_DEPTH];
    logic [PTR_BITS-1:0]  free_head_p;
    logic [PTR_BITS-1:0]  stack_head_p;
    logic [PTR_BITS-1:0]  queue_head_p;
    logic [PTR_BITS-1:0]  queue_tail_p;

    t_pool_result expected_results [$];
    t_pool_result predicted;
    t_pool_result oldest;
    int           mismatch_count = 0;
    int           checked_count  = 0;
    int           refusal_count  = 0;

    function automatic logic is_slot(input logic [PTR_BITS-1:0] p);
        return p < PTR_BITS'(POOL_DEPTH);
    endfunction

    function automatic logic [ITEM_BITS-1:0] word_at(input logic [PTR_BITS-1:0] p);
        return is_slot(p) ? slot_word[p] : '0;
    endfunction

    task automatic clear_pool();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            slot_word[i] = '0;
            slot_link[i] = (i == 0) ? NIL : PTR_BITS'(i - 1);
        end
        free_head_p  = PTR_BITS'(POOL_DEPTH - 1);
        stack_head_p = NIL;
        queue_head_p = NIL;
        queue_tail_p = NIL;
    endtask

    function automatic void release_slot(input logic [PTR_BITS-1:0] s);
        slot_word[s] = '0;
        slot_link[s] = free_head_p;
        free_head_p  = s;
    endfunction

    function automatic t_pool_result pool_step(input t_op op, input logic [ITEM_BITS-1:0] w);
        t_pool_result        r;
        logic [PTR_BITS-1:0] s;
        r.status  = ST_DONE;
        r.slot    = '0;
        r.removed = '0;
        case (op)
            OP_PUSH: begin
                if (!is_slot(free_head_p)) begin
                    r.status = ST_FULL;
                end else begin
                    s            = free_head_p;
                    free_head_p  = slot_link[s];
                    slot_word[s] = w;
                    slot_link[s] = stack_head_p;
                    stack_head_p = s;
                    r.slot       = SLOT_BITS'(s);
                end
            end
            OP_POP: begin
                if (!is_slot(stack_head_p)) begin
                    r.status = ST_EMPTY;
                end else begin
                    s            = stack_head_p;
                    r.removed    = slot_word[s];
                    stack_head_p = slot_link[s];
                    release_slot(s);
                    r.slot       = SLOT_BITS'(s);
                end
            end
            OP_ENQ: begin
                if (!is_slot(free_head_p)) begin
                    r.status = ST_FULL;
                end else begin
                    s            = free_head_p;
                    free_head_p  = slot_link[s];
                    slot_word[s] = w;
                    slot_link[s] = NIL;
                    if (!is_slot(queue_head_p) || !is_slot(queue_tail_p)) begin
                        queue_head_p = s;
                    end else begin
                        slot_link[queue_tail_p] = s;
                    end
                    queue_tail_p = s;
                    r.slot       = SLOT_BITS'(s);
                end
            end
            default: begin
                if (!is_slot(queue_head_p)) begin
                    r.status = ST_EMPTY;
                end else begin
                    s            = queue_head_p;
                    r.removed    = slot_word[s];
                    queue_head_p = slot_link[s];
                    if (!is_slot(queue_head_p)) begin
                        queue_tail_p = NIL;
                    end
                    release_slot(s);
                    r.slot       = SLOT_BITS'(s);
                end
            end
        endcase
        r.top         = word_at(stack_head_p);
        r.front       = word_at(queue_head_p);
        r.stack_empty = !is_slot(stack_head_p);
        r.queue_empty = !is_slot(queue_head_p);
        r.pool_full   = !is_slot(free_head_p);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] result word %0d: %s is 0x%0h, expected 0x%0h",
                     $time, checked_count, field, got, want);
        end
    endtask

    task automatic compare_result(input t_pool_result want);
        if (i_res_mon.status !== want.status)
            report_mismatch("status", 64'(i_res_mon.status), 64'(want.status));
        if (i_res_mon.slot_index !== want.slot)
            report_mismatch("slot_index", 64'(i_res_mon.slot_index), 64'(want.slot));
        if (i_res_mon.removed_item !== want.removed)
            report_mismatch("removed_item", 64'(i_res_mon.removed_item), 64'(want.removed));
        if (i_res_mon.top_item !== want.top)
            report_mismatch("top_item", 64'(i_res_mon.top_item), 64'(want.top));
        if (i_res_mon.front_item !== want.front)
            report_mismatch("front_item", 64'(i_res_mon.front_item), 64'(want.front));
        if (i_res_mon.stack_empty !== want.stack_empty)
            report_mismatch("stack_empty", 64'(i_res_mon.stack_empty), 64'(want.stack_empty));
        if (i_res_mon.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", 64'(i_res_mon.queue_empty), 64'(want.queue_empty));
        if (i_res_mon.pool_full !== want.pool_full)
            report_mismatch("pool_full", 64'(i_res_mon.pool_full), 64'(want.pool_full));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pool();
            expected_results.delete();
        end else begin
            if (i_op_mon.valid && i_op_mon.ready) begin
                predicted = pool_step(t_op'(i_op_mon.opcode), i_op_mon.item_data);
                expected_results.push_back(predicted);
                if (predicted.status != ST_DONE) begin
                    refusal_count++;
                end
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("word with none expected, valid", 64'd1, 64'd0);
                end else begin
                    oldest = expected_results.pop_front();
                    compare_result(oldest);
                end
                checked_count++;
            end
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_results.size();
        o_checked    = checked_count;
        o_refusals   = refusal_count;
    end

endmodule

@@ bench/testbench.sv @@
// ============================================================================
// testbench - stimulus and verdict for the linked stack/queue pool
// Drives push, pop, enqueue and dequeue words with random gaps while the
// result side stalls at random. A directed opening hits both empty
// structures, extreme item words and a full pool; the random part then swings
// the pool between empty and full in phases. Checking sits in
// lsq_pool_checker.
// ============================================================================
module testbench;
    import lsq_pkg::*;

    localparam int POOL_DEPTH     = 16;
    localparam int ITEM_BITS      = 32;
    localparam int RANDOM_BLOCKS  = 34;
    localparam int BLOCK_WORDS    = 50;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lsq_in_if  #(.ITEM_BITS(ITEM_BITS)) op_ch ();
    lsq_out_if #(.ITEM_BITS(ITEM_BITS)) res_ch ();

    int fail_count;
    int pending;
    int checked;
    int refusals;
    int words_sent   = 0;
    int directed_cnt = 0;
    int idle_cycles  = 0;
    bit steady       = 1'b0;

    linked_stack_queue_pool #(
        .POOL_DEPTH(POOL_DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch),
        .o_out  (res_ch)
    );

    lsq_pool_checker #(
        .POOL_DEPTH(POOL_DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_mon    (op_ch),
        .i_res_mon   (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_refusals  (refusals)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // result side stalls; held high through steady phases
    initial begin
        int hold;
        int r;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(99);
                if (steady || r < 65) begin
                    res_ch.ready = 1'b1;
                end else if (r < 92) begin
                    res_ch.ready = 1'b0;
                    hold = $urandom_range(0, 2);
                end else begin
                    res_ch.ready = 1'b0;
                    hold = $urandom_range(5, 30);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // called and returns at a falling edge; valid stays high for a following word
    task automatic send_word(input t_op op, input logic [ITEM_BITS-1:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            op_ch.valid     = 1'b0;
            op_ch.opcode    = OP_BITS'($urandom_range(3));
            op_ch.item_data = ITEM_BITS'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        op_ch.valid     = 1'b1;
        op_ch.opcode    = op;
        op_ch.item_data = w;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        op_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [ITEM_BITS-1:0] random_word();
        int r;
        r = $urandom_range(15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return ITEM_BITS'($urandom);
    endfunction

    initial begin
        int insert_pct;
        op_ch.valid     = 1'b0;
        op_ch.opcode    = OP_PUSH;
        op_ch.item_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty refusals, extreme words, then fill the pool and hit both full refusals
        send_word(OP_POP, '1);
        send_word(OP_DEQ, '1);
        send_word(OP_PUSH, '0);
        send_word(OP_PUSH, '1);
        send_word(OP_POP, '0);
        send_word(OP_ENQ, '1);
        send_word(OP_ENQ, '0);
        send_word(OP_DEQ, '0);
        for (int i = 0; i < POOL_DEPTH - 2; i++) begin
            send_word((i % 2 == 0) ? OP_PUSH : OP_ENQ,
                      ITEM_BITS'(32'hA5A5_0001 << i) ^ ITEM_BITS'(i));
        end
        send_word(OP_PUSH, '1);
        send_word(OP_ENQ, '1);
        directed_cnt = words_sent;
        drain_results();

        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            case ($urandom_range(2))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                default: insert_pct = 80;
            endcase
            steady = ($urandom_range(4) == 0);
            for (int k = 0; k < BLOCK_WORDS; k++) begin
                if ($urandom_range(99) < insert_pct) begin
                    send_word($urandom_range(1) ? OP_PUSH : OP_ENQ, random_word());
                end else begin
                    send_word($urandom_range(1) ? OP_POP : OP_DEQ, random_word());
                end
            end
            if (b % 8 == 5) begin
                drain_results();
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (10) @(negedge i_clk);

        $display("%0d operation words sent (%0d directed), %0d result words checked",
                 words_sent, directed_cnt, checked);
        $display("%0d refused on a full pool or an empty stack or queue", refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
